### rtl/igd_pkg.sv
// Shared types, constants and helper functions of the orientation filter.
package igd_pkg;

  localparam int VW     = 48;
  localparam int MW     = 44;
  localparam int PW     = 2 * MW;
  localparam int ACC_W  = 66;
  localparam int RATE_W = 54;
  localparam int QW     = 32;
  localparam int CNT_W  = 6;
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] STEP_GRAD_LAST  = 6'd15;
  localparam logic [STEP_W-1:0] STEP_RATE_FIRST = 6'd16;
  localparam logic [STEP_W-1:0] STEP_LAST       = 6'd35;

  localparam logic signed [QW-1:0] ONE_Q30  = 32'sh4000_0000;
  localparam logic signed [VW-1:0] RATE_MAX = 48'sh3FF_FFFF_FFFF;

  localparam logic CFG_BETA = 1'b0;
  localparam logic CFG_DT   = 1'b1;

  typedef enum logic [4:0] {
    SRC_W, SRC_X, SRC_Y, SRC_Z,
    SRC_GX, SRC_GY, SRC_GZ,
    SRC_F1, SRC_F2, SRC_F3,
    SRC_BETA, SRC_DT,
    SRC_G0, SRC_G1, SRC_G2, SRC_G3,
    SRC_R0, SRC_R1, SRC_R2, SRC_R3
  } src_e;

  typedef enum logic [2:0] {
    FIN_NONE, FIN_F1, FIN_F2, FIN_F3, FIN_G, FIN_R, FIN_C, FIN_Q
  } fin_e;

  typedef struct packed {
    src_e       a;
    src_e       b;
    logic       neg;
    logic       rnd;
    logic       dbl;
    fin_e       fin;
    logic [1:0] idx;
  } step_t;

  typedef struct packed {
    logic done;
    logic ok;
  } norm_sts_t;

  typedef enum logic [3:0] {
    N_IDLE, N_PRE, N_SQ_START, N_SQ_WAIT, N_SCALE,
    N_SQRT, N_ROUND, N_DIV_LOAD, N_DIV, N_DONE
  } norm_state_e;

  typedef enum logic [3:0] {
    T_IDLE, T_NA, T_NA_WAIT, T_MUL, T_MUL_WAIT, T_FIN,
    T_NG, T_NG_WAIT, T_NQ, T_NQ_WAIT, T_OUT
  } top_state_e;

  function automatic step_t mk(input src_e a, input src_e b, input logic neg,
                               input logic rnd, input logic dbl, input fin_e fin,
                               input logic [1:0] idx);
    step_t s;
    s.a   = a;
    s.b   = b;
    s.neg = neg;
    s.rnd = rnd;
    s.dbl = dbl;
    s.fin = fin;
    s.idx = idx;
    return s;
  endfunction

  function automatic step_t prog(input logic [STEP_W-1:0] s);
    step_t p;
    unique case (s)
      6'd0:  p = mk(SRC_X, SRC_Z, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd1:  p = mk(SRC_W, SRC_Y, 1'b1, 1'b0, 1'b0, FIN_F1, 2'd0);
      6'd2:  p = mk(SRC_W, SRC_X, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd3:  p = mk(SRC_Y, SRC_Z, 1'b0, 1'b0, 1'b0, FIN_F2, 2'd0);
      6'd4:  p = mk(SRC_X, SRC_X, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd5:  p = mk(SRC_Y, SRC_Y, 1'b0, 1'b0, 1'b0, FIN_F3, 2'd0);
      6'd6:  p = mk(SRC_X, SRC_F2, 1'b0, 1'b1, 1'b0, FIN_NONE, 2'd0);
      6'd7:  p = mk(SRC_Y, SRC_F1, 1'b1, 1'b1, 1'b0, FIN_G, 2'd0);
      6'd8:  p = mk(SRC_Z, SRC_F1, 1'b0, 1'b1, 1'b0, FIN_NONE, 2'd0);
      6'd9:  p = mk(SRC_W, SRC_F2, 1'b0, 1'b1, 1'b0, FIN_NONE, 2'd0);
      6'd10: p = mk(SRC_X, SRC_F3, 1'b1, 1'b1, 1'b1, FIN_G, 2'd1);
      6'd11: p = mk(SRC_Z, SRC_F2, 1'b0, 1'b1, 1'b0, FIN_NONE, 2'd0);
      6'd12: p = mk(SRC_Y, SRC_F3, 1'b1, 1'b1, 1'b1, FIN_NONE, 2'd0);
      6'd13: p = mk(SRC_W, SRC_F1, 1'b1, 1'b1, 1'b0, FIN_G, 2'd2);
      6'd14: p = mk(SRC_X, SRC_F1, 1'b0, 1'b1, 1'b0, FIN_NONE, 2'd0);
      6'd15: p = mk(SRC_Y, SRC_F2, 1'b0, 1'b1, 1'b0, FIN_G, 2'd3);
      6'd16: p = mk(SRC_X, SRC_GX, 1'b1, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd17: p = mk(SRC_Y, SRC_GY, 1'b1, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd18: p = mk(SRC_Z, SRC_GZ, 1'b1, 1'b0, 1'b0, FIN_R, 2'd0);
      6'd19: p = mk(SRC_W, SRC_GX, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd20: p = mk(SRC_Y, SRC_GZ, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd21: p = mk(SRC_Z, SRC_GY, 1'b1, 1'b0, 1'b0, FIN_R, 2'd1);
      6'd22: p = mk(SRC_W, SRC_GY, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd23: p = mk(SRC_X, SRC_GZ, 1'b1, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd24: p = mk(SRC_Z, SRC_GX, 1'b0, 1'b0, 1'b0, FIN_R, 2'd2);
      6'd25: p = mk(SRC_W, SRC_GZ, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd26: p = mk(SRC_X, SRC_GY, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
      6'd27: p = mk(SRC_Y, SRC_GX, 1'b1, 1'b0, 1'b0, FIN_R, 2'd3);
      6'd28: p = mk(SRC_BETA, SRC_G0, 1'b0, 1'b0, 1'b0, FIN_C, 2'd0);
      6'd29: p = mk(SRC_BETA, SRC_G1, 1'b0, 1'b0, 1'b0, FIN_C, 2'd1);
      6'd30: p = mk(SRC_BETA, SRC_G2, 1'b0, 1'b0, 1'b0, FIN_C, 2'd2);
      6'd31: p = mk(SRC_BETA, SRC_G3, 1'b0, 1'b0, 1'b0, FIN_C, 2'd3);
      6'd32: p = mk(SRC_R0, SRC_DT, 1'b0, 1'b0, 1'b0, FIN_Q, 2'd0);
      6'd33: p = mk(SRC_R1, SRC_DT, 1'b0, 1'b0, 1'b0, FIN_Q, 2'd1);
      6'd34: p = mk(SRC_R2, SRC_DT, 1'b0, 1'b0, 1'b0, FIN_Q, 2'd2);
      6'd35: p = mk(SRC_R3, SRC_DT, 1'b0, 1'b0, 1'b0, FIN_Q, 2'd3);
      default: p = mk(SRC_W, SRC_W, 1'b0, 1'b0, 1'b0, FIN_NONE, 2'd0);
    endcase
    return p;
  endfunction

  // round half away from zero
  function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                   input int unsigned sh);
    logic [ACC_W-1:0] m;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    m = (m + (ACC_W'(1) << (sh - 1))) >> sh;
    return v[ACC_W-1] ? $signed(-m) : $signed(m);
  endfunction

endpackage

### rtl/igd_mul.sv
// Bit-serial shift-and-add multiplier of two unsigned magnitudes.
module igd_mul
  import igd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] a_i,
  input  logic [MW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  logic [MW-1:0]    a_q;
  logic [PW-1:0]    prod_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [MW:0]      sum;

  assign sum    = {1'b0, prod_q[PW-1:MW]} + (prod_q[0] ? {1'b0, a_q} : '0);
  assign done_o = done_q;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(MW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {MW'(0), b_i};
    end else if (cnt_q != '0) begin
      prod_q <= {sum, prod_q[MW-1:1]};
    end
  end

endmodule

### rtl/igd_norm.sv
// Vector normalizer: serial squares, bit-serial square root and long division.
module igd_norm
  import igd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [VW-1:0] vec_i [4],
  output norm_sts_t            sts_o,
  output logic signed [QW-1:0] res_o [4]
);

  localparam int DIV_W = 34;
  localparam int SQ_W  = 62;
  localparam int DVD_W = 92;

  norm_state_e state_q, state_d;

  logic [VW-1:0]      mag_q [4];
  logic [3:0]         neg_q;
  logic [1:0]         idx_q;
  logic [63:0]        sum_q;
  logic [4:0]         k_q;
  logic               kneg_q;
  logic [SQ_W-1:0]    rem_q, root_q, bit_q;
  logic [DIV_W-2:0]   den_q;
  logic [DIV_W-1:0]   drem_q, dvd_q, quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               ok_q;
  logic signed [QW-1:0] res_q [4];

  logic               mul_start, mul_done;
  logic [PW-1:0]      mul_prod;
  logic [MW-1:0]      sq_op;
  logic               wide;
  logic [SQ_W-1:0]    trial;
  logic               sq_ge;
  logic [31:0]        root_rnd;
  logic [4:0]         kp;
  logic [DVD_W-1:0]   dvd_full;
  logic [DIV_W-1:0]   r2, quo_next;
  logic               div_ge;
  logic [QW-1:0]      qclamp;

  assign sq_op = MW'(mag_q[idx_q][30:0]);

  igd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (sq_op),
    .b_i     (sq_op),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    wide = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (mag_q[i][VW-1:31] != '0) wide = 1'b1;
    end
  end

  assign trial    = root_q + bit_q;
  assign sq_ge    = (rem_q >= trial);
  assign root_rnd = root_q[31:0] + ((rem_q > root_q) ? 32'd1 : 32'd0);
  assign kp       = kneg_q ? 5'd0 : k_q;
  assign dvd_full = (DVD_W'(mag_q[idx_q][30:0]) << (7'd30 + 7'(kp)))
                    + DVD_W'(den_q >> 1);
  assign r2       = {drem_q[DIV_W-2:0], dvd_q[DIV_W-1]};
  assign div_ge   = (r2 >= {1'b0, den_q});
  assign quo_next = {quo_q[DIV_W-2:0], div_ge};
  assign qclamp   = (quo_next > DIV_W'(ONE_Q30)) ? ONE_Q30 : quo_next[QW-1:0];

  assign sts_o.done = (state_q == N_DONE);
  assign sts_o.ok   = ok_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= N_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    unique case (state_q)
      N_IDLE:     if (start_i) state_d = N_PRE;
      N_PRE:      if (!wide) state_d = N_SQ_START;
      N_SQ_START: begin
        mul_start = 1'b1;
        state_d   = N_SQ_WAIT;
      end
      N_SQ_WAIT:  if (mul_done) state_d = (idx_q == 2'd3) ? N_SCALE : N_SQ_START;
      N_SCALE: begin
        if (sum_q == '0) state_d = N_DONE;
        else if (sum_q[63:62] == '0 && sum_q[61:60] != '0) state_d = N_SQRT;
      end
      N_SQRT:     if (bit_q[0]) state_d = N_ROUND;
      N_ROUND:    state_d = N_DIV_LOAD;
      N_DIV_LOAD: state_d = N_DIV;
      N_DIV:      if (cnt_q == CNT_W'(1)) state_d = (idx_q == 2'd3) ? N_DONE : N_DIV_LOAD;
      N_DONE:     state_d = N_IDLE;
      default:    state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (state_q == N_IDLE && start_i) begin
      ok_q <= 1'b0;
    end else if (state_q == N_SQRT) begin
      ok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 4; i++) begin
            mag_q[i] <= vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
            neg_q[i] <= vec_i[i][VW-1];
          end
          idx_q  <= '0;
          sum_q  <= '0;
          k_q    <= '0;
          kneg_q <= 1'b0;
        end
      end
      N_PRE: begin
        if (wide) begin
          for (int i = 0; i < 4; i++) mag_q[i] <= mag_q[i] >> 1;
        end
      end
      N_SQ_START: ;
      N_SQ_WAIT: begin
        if (mul_done) begin
          sum_q <= sum_q + mul_prod[63:0];
          idx_q <= idx_q + 2'd1;
        end
      end
      N_SCALE: begin
        if (sum_q[63:62] != '0) begin
          sum_q  <= sum_q >> 2;
          kneg_q <= 1'b1;
        end else if (sum_q[63:60] == '0) begin
          sum_q <= sum_q << 2;
          k_q   <= k_q + 5'd1;
        end else begin
          rem_q  <= sum_q[SQ_W-1:0];
          root_q <= '0;
          bit_q  <= SQ_W'(1) << 60;
        end
      end
      N_SQRT: begin
        if (sq_ge) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_ROUND: begin
        den_q <= kneg_q ? {root_rnd, 1'b0} : {1'b0, root_rnd};
        idx_q <= '0;
      end
      N_DIV_LOAD: begin
        drem_q <= dvd_full[67:34];
        dvd_q  <= dvd_full[33:0];
        quo_q  <= '0;
        cnt_q  <= CNT_W'(DIV_W);
      end
      N_DIV: begin
        drem_q <= div_ge ? (r2 - {1'b0, den_q}) : r2;
        quo_q  <= quo_next;
        dvd_q  <= dvd_q << 1;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          res_q[idx_q] <= neg_q[idx_q] ? $signed(-qclamp) : $signed(qclamp);
          idx_q        <= idx_q + 2'd1;
        end
      end
      N_DONE: ;
      default: ;
    endcase
  end

endmodule

### rtl/imu_gradient_descent_orientation.sv
// Top level: six-axis gradient-descent orientation filter with a serial datapath.
// Each sample runs 36 products on the bit-serial multiplier and three normalizer passes
// (serial squares, root, four divisions); zero vectors skip part of this work.
// A new sample is taken only once the filter is idle again; a stalled result holds it off.
// Reset sets the quaternion to (1,0,0,0) and the gain and time step to their defaults.
module imu_gradient_descent_orientation
  import igd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [19:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [QW-1:0]           quat_w_o,
  output logic signed [QW-1:0]           quat_x_o,
  output logic signed [QW-1:0]           quat_y_o,
  output logic signed [QW-1:0]           quat_z_o
);

  top_state_e state_q, state_d;

  logic [15:0]              beta_q;
  logic [19:0]              dt_q;
  logic signed [QW-1:0]     ori_q [4];
  logic signed [VW-1:0]     gyro_q [3];
  logic signed [VW-1:0]     accel_q [3];
  logic signed [QW-1:0]     an_q [3];
  logic signed [VW-1:0]     f_q [3];
  logic signed [VW-1:0]     grad_q [4];
  logic signed [RATE_W-1:0] rate_q [4];
  logic signed [VW-1:0]     rr_q [4];
  logic signed [VW-1:0]     qn_q [4];
  logic signed [ACC_W-1:0]  acc_q;
  logic [STEP_W-1:0]        step_q;
  logic                     corr_q;
  logic signed [QW-1:0]     out_q [4];
  logic                     out_valid_q;

  step_t                    st;
  logic signed [VW-1:0]     a_val, b_val;
  logic [MW-1:0]            a_mag, b_mag;
  logic                     p_neg;
  logic [ACC_W-1:0]         pm;
  logic signed [ACC_W-1:0]  term;
  logic signed [RATE_W-1:0] corr_t;
  logic signed [VW-1:0]     corr_sat;

  logic                     mul_start, mul_done;
  logic [PW-1:0]            mul_prod;
  logic                     norm_start;
  norm_sts_t                norm_sts;
  logic signed [VW-1:0]     norm_vec [4];
  logic signed [QW-1:0]     norm_res [4];
  logic                     load_out;

  assign st = prog(step_q);

  function automatic logic signed [VW-1:0] pick(input src_e s);
    logic signed [VW-1:0] v;
    unique case (s)
      SRC_W:    v = VW'(ori_q[0]);
      SRC_X:    v = VW'(ori_q[1]);
      SRC_Y:    v = VW'(ori_q[2]);
      SRC_Z:    v = VW'(ori_q[3]);
      SRC_GX:   v = gyro_q[0];
      SRC_GY:   v = gyro_q[1];
      SRC_GZ:   v = gyro_q[2];
      SRC_F1:   v = f_q[0];
      SRC_F2:   v = f_q[1];
      SRC_F3:   v = f_q[2];
      SRC_BETA: v = corr_q ? $signed(VW'(beta_q)) : '0;
      SRC_DT:   v = $signed(VW'(dt_q));
      SRC_G0:   v = grad_q[0];
      SRC_G1:   v = grad_q[1];
      SRC_G2:   v = grad_q[2];
      SRC_G3:   v = grad_q[3];
      SRC_R0:   v = rr_q[0];
      SRC_R1:   v = rr_q[1];
      SRC_R2:   v = rr_q[2];
      SRC_R3:   v = rr_q[3];
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    a_val = pick(st.a);
    b_val = pick(st.b);
  end

  assign a_mag = a_val[VW-1] ? MW'(-a_val) : MW'(a_val);
  assign b_mag = b_val[VW-1] ? MW'(-b_val) : MW'(b_val);
  assign p_neg = a_val[VW-1] ^ b_val[VW-1] ^ st.neg;

  always_comb begin
    pm = mul_prod[ACC_W-1:0];
    if (st.rnd) pm = (pm + (ACC_W'(1) << 29)) >> 30;
    if (st.dbl) pm = pm << 1;
    term = p_neg ? $signed(-pm) : $signed(pm);
  end

  assign corr_t = rate_q[st.idx] - RATE_W'(rshr(acc_q, 16));

  always_comb begin
    if (corr_t > RATE_W'(RATE_MAX))       corr_sat = RATE_MAX;
    else if (corr_t < -RATE_W'(RATE_MAX)) corr_sat = -RATE_MAX;
    else                                  corr_sat = VW'(corr_t);
  end

  igd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a_mag),
    .b_i     (b_mag),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    norm_vec = qn_q;
    if (state_q == T_NA) begin
      norm_vec[0] = accel_q[0];
      norm_vec[1] = accel_q[1];
      norm_vec[2] = accel_q[2];
      norm_vec[3] = '0;
    end else if (state_q == T_NG) begin
      norm_vec = grad_q;
    end
  end

  igd_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .sts_o   (norm_sts),
    .res_o   (norm_res)
  );

  assign in_stall_o  = (state_q != T_IDLE);
  assign out_valid_o = out_valid_q;
  assign quat_w_o    = out_q[0];
  assign quat_x_o    = out_q[1];
  assign quat_y_o    = out_q[2];
  assign quat_z_o    = out_q[3];
  assign load_out    = (state_q == T_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= T_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    norm_start = 1'b0;
    unique case (state_q)
      T_IDLE:     if (in_valid_i) state_d = T_NA;
      T_NA: begin
        norm_start = 1'b1;
        state_d    = T_NA_WAIT;
      end
      T_NA_WAIT:  if (norm_sts.done) state_d = T_MUL;
      T_MUL: begin
        mul_start = 1'b1;
        state_d   = T_MUL_WAIT;
      end
      T_MUL_WAIT: if (mul_done) state_d = (st.fin != FIN_NONE) ? T_FIN : T_MUL;
      T_FIN: begin
        if (step_q == STEP_GRAD_LAST) state_d = T_NG;
        else if (step_q == STEP_LAST) state_d = T_NQ;
        else                          state_d = T_MUL;
      end
      T_NG: begin
        norm_start = 1'b1;
        state_d    = T_NG_WAIT;
      end
      T_NG_WAIT:  if (norm_sts.done) state_d = T_MUL;
      T_NQ: begin
        norm_start = 1'b1;
        state_d    = T_NQ_WAIT;
      end
      T_NQ_WAIT:  if (norm_sts.done) state_d = T_OUT;
      T_OUT:      if (load_out) state_d = T_IDLE;
      default:    state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q      <= 16'd4953;
      dt_q        <= 20'd5243;
      ori_q[0]    <= ONE_Q30;
      ori_q[1]    <= '0;
      ori_q[2]    <= '0;
      ori_q[3]    <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      corr_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BETA: beta_q <= cfg_data_i[15:0];
          CFG_DT:   dt_q   <= cfg_data_i;
          default:  ;
        endcase
      end
      if (load_out)                      out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == T_NA_WAIT && norm_sts.done) begin
        corr_q <= 1'b0;
        step_q <= norm_sts.ok ? '0 : STEP_RATE_FIRST;
      end
      if (state_q == T_NG_WAIT && norm_sts.done) begin
        corr_q <= norm_sts.ok;
        step_q <= STEP_RATE_FIRST;
      end
      if ((state_q == T_MUL_WAIT && mul_done && st.fin == FIN_NONE) ||
          (state_q == T_FIN && step_q != STEP_GRAD_LAST && step_q != STEP_LAST)) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == T_NQ_WAIT && norm_sts.done) begin
        for (int i = 0; i < 4; i++) ori_q[i] <= norm_sts.ok ? norm_res[i] : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_IDLE && in_valid_i) begin
      gyro_q[0]  <= VW'(gyro_x_i);
      gyro_q[1]  <= VW'(gyro_y_i);
      gyro_q[2]  <= VW'(gyro_z_i);
      accel_q[0] <= VW'(accel_x_i);
      accel_q[1] <= VW'(accel_y_i);
      accel_q[2] <= VW'(accel_z_i);
      acc_q      <= '0;
    end
    if (state_q == T_NA_WAIT && norm_sts.done) begin
      for (int i = 0; i < 3; i++) an_q[i] <= norm_res[i];
    end
    if (state_q == T_NG_WAIT && norm_sts.done) begin
      for (int i = 0; i < 4; i++) grad_q[i] <= VW'(norm_res[i]);
    end
    if (state_q == T_MUL_WAIT && mul_done) begin
      acc_q <= acc_q + term;
    end
    if (state_q == T_FIN) begin
      acc_q <= '0;
      unique case (st.fin)
        FIN_F1: f_q[0] <= VW'(rshr(acc_q, 29)) - VW'(an_q[0]);
        FIN_F2: f_q[1] <= VW'(rshr(acc_q, 29)) - VW'(an_q[1]);
        FIN_F3: f_q[2] <= VW'(ONE_Q30) - VW'(rshr(acc_q, 29)) - VW'(an_q[2]);
        FIN_G:  grad_q[st.idx] <= VW'(acc_q);
        FIN_R:  rate_q[st.idx] <= RATE_W'(rshr(acc_q, 13));
        FIN_C:  rr_q[st.idx] <= corr_sat;
        FIN_Q:  qn_q[st.idx] <= VW'(ori_q[st.idx]) + VW'(rshr(acc_q, 20));
        default: ;
      endcase
    end
    if (load_out) out_q <= ori_q;
  end

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == T_OUT))
    else $error("result appeared without a finished update");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quat_w_o <= ONE_Q30) && (quat_w_o >= -ONE_Q30) &&
                    (quat_z_o <= ONE_Q30) && (quat_z_o >= -ONE_Q30))
    else $error("quaternion component outside unit range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == T_NA))
    else $error("accepted sample did not start normalization");

endmodule

### bench/tb_imu_gradient_descent_orientation.sv
// Testbench: orientation filter checked sample by sample against a fixed-point predictor.
`timescale 1ns / 1ps

module tb_imu_gradient_descent_orientation
  import igd_pkg::*;
();

  typedef longint vec4_t[4];
  typedef struct {
    logic signed [QW-1:0] w, x, y, z;
  } quat_t;
  typedef struct {
    logic signed [15:0] gx, gy, gz, ax, ay, az;
    bit    typed;
    quat_t q;
  } sample_row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we_i = 1'b0, cfg_idx_i = 1'b0;
  logic [19:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, out_stall_i = 1'b0;
  logic signed [15:0] gyro_x_i = '0, gyro_y_i = '0, gyro_z_i = '0;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic in_stall_o, out_valid_o;
  logic signed [QW-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  imu_gradient_descent_orientation uut (.*);

  logic signed [31:0] att_w, att_x, att_y, att_z;
  longint unsigned gain_q16, dt_q20;
  quat_t quat_queue[$];
  int errors = 0;
  int tx_pct = 0, rx_pct = 0;
  int unsigned cycles = 0;
  bit done = 1'b0;
  sample_row_t rows[$];

  initial forever #6 clk_i = ~clk_i;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint unsigned m;
    m = (mag64(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_round(longint unsigned m);
    longint unsigned rem, res, b;
    rem = m;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic bit unit_vec(inout vec4_t v, input int n);
    longint unsigned a[4], mx, s, den, num, qq;
    int k, pre;
    mx = 0;
    s = 0;
    k = 0;
    pre = 0;
    for (int i = 0; i < n; i++) begin
      a[i] = mag64(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    while ((mx >> pre) >= (64'd1 << 31)) pre++;
    for (int i = 0; i < n; i++) begin
      a[i] >>= pre;
      s += a[i] * a[i];
    end
    if (s == 0) return 1'b0;
    if (s >= (64'd1 << 62)) begin
      s >>= 2;
      k = -1;
    end else begin
      while (s < (64'd1 << 60)) begin
        s <<= 2;
        k++;
      end
    end
    den = root_round(s);
    if (k < 0) den <<= 1;
    for (int i = 0; i < n; i++) begin
      num = a[i] << (30 + (k < 0 ? 0 : k));
      qq = (num + den / 2) / den;
      if (qq > 64'd1 << 30) qq = 64'd1 << 30;
      v[i] = v[i] < 0 ? -longint'(qq) : longint'(qq);
    end
    return 1'b1;
  endfunction

  function automatic quat_t advance_attitude(sample_row_t r);
    longint w, x, y, z, gx, gy, gz, f1, f2, f3, t;
    vec4_t acc, grad, rate, q;
    bit corr;
    quat_t res;
    w = att_w; x = att_x; y = att_y; z = att_z;
    gx = r.gx; gy = r.gy; gz = r.gz;
    acc = '{r.ax, r.ay, r.az, 0};
    grad = '{0, 0, 0, 0};
    corr = 1'b0;
    if (unit_vec(acc, 3)) begin
      f1 = round_shift(x * z - w * y, 29) - acc[0];
      f2 = round_shift(w * x + y * z, 29) - acc[1];
      f3 = (64'sd1 << 30) - round_shift(x * x + y * y, 29) - acc[2];
      grad[0] = round_shift(x * f2, 30) - round_shift(y * f1, 30);
      grad[1] = round_shift(z * f1, 30) + round_shift(w * f2, 30)
              - 2 * round_shift(x * f3, 30);
      grad[2] = round_shift(z * f2, 30) - 2 * round_shift(y * f3, 30)
              - round_shift(w * f1, 30);
      grad[3] = round_shift(x * f1, 30) + round_shift(y * f2, 30);
      corr = unit_vec(grad, 4);
    end
    rate[0] = round_shift(-x * gx - y * gy - z * gz, 13);
    rate[1] = round_shift(w * gx + y * gz - z * gy, 13);
    rate[2] = round_shift(w * gy - x * gz + z * gx, 13);
    rate[3] = round_shift(w * gz + x * gy - y * gx, 13);
    q = '{w, x, y, z};
    for (int i = 0; i < 4; i++) begin
      t = rate[i];
      if (corr) t -= round_shift(longint'(gain_q16) * grad[i], 16);
      if (t > longint'(RATE_MAX)) t = RATE_MAX;
      if (t < -longint'(RATE_MAX)) t = -longint'(RATE_MAX);
      q[i] += round_shift(t * longint'(dt_q20), 20);
    end
    if (!unit_vec(q, 4)) q = '{0, 0, 0, 0};
    att_w = q[0]; att_x = q[1]; att_y = q[2]; att_z = q[3];
    res.w = q[0]; res.x = q[1]; res.y = q[2]; res.z = q[3];
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= ($urandom_range(99) < rx_pct);
    if (cycles > 40_000_000 && !done) begin
      $display("FAIL imu_gradient_descent_orientation");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quat_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer");
      end else begin
        e = quat_queue.pop_front();
        if (e.w !== quat_w_o || e.x !== quat_x_o || e.y !== quat_y_o || e.z !== quat_z_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                     e.w, e.x, e.y, e.z, quat_w_o, quat_x_o, quat_y_o, quat_z_o);
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_BETA) gain_q16 = val[15:0];
    else dt_q20 = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_sample(sample_row_t r);
    quat_t e;
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    gyro_x_i <= r.gx; gyro_y_i <= r.gy; gyro_z_i <= r.gz;
    accel_x_i <= r.ax; accel_y_i <= r.ay; accel_z_i <= r.az;
    do @(posedge clk_i); while (in_stall_o);
    e = advance_attitude(r);
    quat_queue.push_back(r.typed ? r.q : e);
  endtask

  function automatic sample_row_t mk_row(int gx, int gy, int gz, int ax, int ay, int az,
                                         bit typed = 0);
    sample_row_t r;
    r.gx = gx; r.gy = gy; r.gz = gz; r.ax = ax; r.ay = ay; r.az = az;
    r.typed = typed;
    r.q.w = ONE_Q30; r.q.x = 0; r.q.y = 0; r.q.z = 0;
    return r;
  endfunction

  function automatic logic signed [15:0] pick(bit wide);
    int c;
    c = $urandom_range(9);
    if (wide || c == 0) return 16'($urandom);
    if (c == 1) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    return $signed(16'($urandom_range(4000))) - 16'sd2000;
  endfunction

  initial begin
    logic [19:0] betas[4], dts[4];
    sample_row_t r;
    int ph;
    att_w = ONE_Q30; att_x = 0; att_y = 0; att_z = 0;
    gain_q16 = 4953;
    dt_q20 = 5243;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first rows: identity stays put while gyro is zero and acceleration is zero or lies on z
    rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1));
    rows.push_back(mk_row(0, 0, 0, 0, 0, 1, 1));
    rows.push_back(mk_row(0, 0, 0, 0, 0, -32768, 1));
    rows.push_back(mk_row(0, 0, 0, 0, 0, 32767, 1));
    rows.push_back(mk_row(32767, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, -32768, 0, 1, 0, 0));
    rows.push_back(mk_row(0, 0, 32767, 0, -1, 0));
    rows.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768));
    rows.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767));
    rows.push_back(mk_row(-1, -1, -1, -1, -1, -1));
    rows.push_back(mk_row(21845, -21846, 10922, 100, -200, 16384));
    rows.push_back(mk_row(0, 0, 0, 32767, -32768, 0));
    rows.push_back(mk_row(0, 0, 0, 0, 0, 0));
    foreach (rows[i]) send_sample(rows[i]);
    drain();

    rows.delete();
    rows.push_back(mk_row(32767, -32768, 32767, 5, -7, 32767));
    rows.push_back(mk_row(-32768, 32767, -32768, -32768, 1, 2));
    rows.push_back(mk_row(1000, -2000, 3000, 0, 0, 0));
    rows.push_back(mk_row(-32768, -32768, 32767, 32767, 32767, -32768));
    write_reg(CFG_BETA, 20'hFFFF);
    write_reg(CFG_DT, 20'hFFFFF);
    foreach (rows[i]) send_sample(rows[i]);
    drain();
    write_reg(CFG_BETA, 20'h0);
    write_reg(CFG_DT, 20'h0);
    foreach (rows[i]) send_sample(rows[i]);
    drain();

    betas = '{20'd4953, 20'hFFFF, 20'd0, 20'd0};
    dts   = '{20'd5243, 20'd1, 20'hFFFFF, 20'd0};
    for (int mode = 0; mode < 3; mode++) begin
      tx_pct = (mode == 0) ? 32 : (mode == 1) ? 72 : 0;
      rx_pct = (mode == 0) ? 72 : (mode == 1) ? 32 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        drain();
        ph = mode * 2 + sub;
        if (ph < 4) begin
          write_reg(CFG_BETA, betas[ph]);
          write_reg(CFG_DT, dts[ph]);
        end else begin
          write_reg(CFG_BETA, 20'($urandom_range(65535)));
          write_reg(CFG_DT, 20'($urandom_range(20000)));
        end
        for (int n = 0; n < 200; n++) begin
          r = mk_row(0, 0, 0, 0, 0, 0);
          r.gx = pick(0); r.gy = pick(0); r.gz = pick(0);
          r.ax = pick(1); r.ay = pick(1); r.az = pick(1);
          send_sample(r);
        end
      end
    end
    drain();
    repeat (3200) @(posedge clk_i);
    done = 1'b1;
    if (errors == 0 && quat_queue.size() == 0)
      $display("PASS imu_gradient_descent_orientation");
    else
      $display("FAIL imu_gradient_descent_orientation");
    $finish;
  end

endmodule

### filelist.f
rtl/igd_pkg.sv
rtl/igd_mul.sv
rtl/igd_norm.sv
rtl/imu_gradient_descent_orientation.sv
bench/tb_imu_gradient_descent_orientation.sv
